// ===== hdl/bfs_pkg.sv =====
// shared types and codes for the best-flip bipartition search block
package bfs_pkg;

  // action codes
  localparam logic [2:0] ACT_CLEAR    = 3'd0;
  localparam logic [2:0] ACT_ADD      = 3'd1;
  localparam logic [2:0] ACT_COLOR    = 3'd2;
  localparam logic [2:0] ACT_FLIP_ANY = 3'd3;
  localparam logic [2:0] ACT_FLIP_C0  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_IGNORED  = 2'd1;
  localparam logic [1:0] ST_NO_CAND  = 2'd2;

  localparam int CE_W = 15;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] vertex_a;
    logic [7:0] vertex_b;
    logic       color_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [7:0]      chosen_vertex;
    logic [CE_W-1:0] score;
    logic [CE_W-1:0] edges_color0;
    logic [CE_W-1:0] edges_color1;
  } out_item_t;

  // per-vertex record: colour, same-colour neighbours, degree
  typedef struct packed {
    logic       color;
    logic [7:0] scn;
    logic [7:0] deg;
  } word_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CLR,
    DP_ADD_RD,
    DP_ADD_CHK,
    DP_ADD_WB,
    DP_ADD_WA,
    DP_COL_RD,
    DP_FLIP_RD,
    DP_FLIP_UPD,
    DP_NBR,
    DP_SCAN
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       load;
    logic       reply;
    logic [1:0] rstat;
    logic       rchosen;
  } dp_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic is_dup;
    logic col_same;
    logic clr_last;
    logic nbr_done;
    logic scan_done;
    logic found;
  } dp_stat_t;

endpackage

// ===== hdl/bfs_ram.sv =====
// generic single-write, single-read ram with registered read data
module bfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bfs_ctrl.sv =====
// sequencing state machine for the best-flip search block
module bfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        action,
  input  bfs_pkg::dp_stat_t stat,
  output bfs_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import bfs_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_CLR      = 12'b0000_0000_0010,
    S_ADD_RD   = 12'b0000_0000_0100,
    S_ADD_CHK  = 12'b0000_0000_1000,
    S_ADD_WB   = 12'b0000_0001_0000,
    S_ADD_WA   = 12'b0000_0010_0000,
    S_COL_RD   = 12'b0000_0100_0000,
    S_COL_CHK  = 12'b0000_1000_0000,
    S_FLIP_RD  = 12'b0001_0000_0000,
    S_FLIP_UPD = 12'b0010_0000_0000,
    S_NBR      = 12'b0100_0000_0000,
    S_SCAN     = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   clr_reply, clr_reply_next;
  logic   step, step_next;

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    clr_reply_next = clr_reply;
    step_next      = step;
    cmd            = '{op: DP_IDLE, load: 1'b0, reply: 1'b0, rstat: ST_DONE, rchosen: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          step_next = (action == ACT_FLIP_ANY) || (action == ACT_FLIP_C0);
          if (action == ACT_CLEAR) begin
            state_next     = S_CLR;
            clr_reply_next = 1'b1;
          end else if (action == ACT_ADD) begin
            state_next = S_ADD_RD;
          end else if (action == ACT_COLOR) begin
            state_next = S_COL_RD;
          end else if (action == ACT_FLIP_ANY || action == ACT_FLIP_C0) begin
            state_next = S_SCAN;
          end else begin
            cmd.reply = 1'b1;
            cmd.rstat = ST_IGNORED;
          end
        end
      end
      S_CLR: begin
        cmd.op = DP_CLR;
        if (stat.clr_last) begin
          cmd.reply      = clr_reply;
          clr_reply_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      S_ADD_RD: begin
        if (!stat.range_ok) begin
          cmd.reply  = 1'b1;
          cmd.rstat  = ST_IGNORED;
          state_next = S_IDLE;
        end else begin
          cmd.op     = DP_ADD_RD;
          state_next = S_ADD_CHK;
        end
      end
      S_ADD_CHK: begin
        cmd.op = DP_ADD_CHK;
        if (stat.is_dup) begin
          cmd.reply  = 1'b1;
          cmd.rstat  = ST_IGNORED;
          state_next = S_IDLE;
        end else begin
          state_next = S_ADD_WB;
        end
      end
      S_ADD_WB: begin
        cmd.op     = DP_ADD_WB;
        state_next = S_ADD_WA;
      end
      S_ADD_WA: begin
        cmd.op     = DP_ADD_WA;
        cmd.reply  = 1'b1;
        state_next = S_IDLE;
      end
      S_COL_RD: begin
        if (!stat.range_ok) begin
          cmd.reply  = 1'b1;
          cmd.rstat  = ST_IGNORED;
          state_next = S_IDLE;
        end else begin
          cmd.op     = DP_COL_RD;
          state_next = S_COL_CHK;
        end
      end
      S_COL_CHK: begin
        if (stat.col_same) begin
          cmd.reply  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_FLIP_RD;
        end
      end
      S_FLIP_RD: begin
        cmd.op     = DP_FLIP_RD;
        state_next = S_FLIP_UPD;
      end
      S_FLIP_UPD: begin
        cmd.op     = DP_FLIP_UPD;
        state_next = S_NBR;
      end
      S_NBR: begin
        cmd.op = DP_NBR;
        if (stat.nbr_done) begin
          cmd.reply   = 1'b1;
          cmd.rchosen = step;
          state_next  = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.op = DP_SCAN;
        if (stat.scan_done) begin
          if (stat.found) begin
            state_next = S_FLIP_RD;
          end else begin
            cmd.reply  = 1'b1;
            cmd.rstat  = ST_NO_CAND;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers; reset starts with a silent clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_reply <= 1'b0;
      step      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_reply <= clr_reply_next;
      step      <= step_next;
    end
  end

endmodule

// ===== hdl/bfs_datapath.sv =====
// graph storage, counters, scan compare and result register
module bfs_datapath #(
  parameter int MAX_VERTICES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  bfs_pkg::dp_cmd_t   cmd,
  output bfs_pkg::dp_stat_t  stat,
  input  bfs_pkg::in_item_t  in_item,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata,
  output logic               result_valid,
  output bfs_pkg::out_item_t result
);
  import bfs_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int WW = $bits(word_t);

  logic [8:0]              vertex_count;
  in_item_t                item;
  logic [CW-1:0]           cnt;
  logic                    pend;
  logic [AW-1:0]           pend_idx;
  logic [AW-1:0]           v;
  logic                    c_old;
  logic [MAX_VERTICES-1:0] adj_row;
  logic [CE_W-1:0]         ce0, ce1;
  logic [CE_W:0]           best;
  logic                    found;
  word_t                   wa;
  logic                    eq;

  logic [CW-1:0]           n;
  logic [AW-1:0]           addr_a, addr_b;
  logic                    a_ok, b_ok;

  logic                    w_we;
  logic [AW-1:0]           w_waddr;
  word_t                   w_wdata;
  logic [WW-1:0]           w_rdata;
  word_t                   rd;
  logic                    a_we;
  logic [AW-1:0]           a_waddr;
  logic [MAX_VERTICES-1:0] a_wdata, a_rdata;
  logic [AW-1:0]           raddr;

  logic                    eq_n;
  logic [CE_W-1:0]         ce_same, ce_other;
  logic [CE_W:0]           gain, keep, val;
  logic                    better;

  assign rd = word_t'(w_rdata);

  // effective vertex count and range checks on the held item
  always_comb begin
    if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = CW'(vertex_count);
    end
  end
  assign addr_a = AW'(item.vertex_a);
  assign addr_b = AW'(item.vertex_b);
  assign a_ok   = 32'(item.vertex_a) < 32'(n);
  assign b_ok   = 32'(item.vertex_b) < 32'(n);

  // scan candidate value
  assign eq_n     = (wa.color == rd.color);
  assign ce_same  = rd.color ? ce1 : ce0;
  assign ce_other = rd.color ? ce0 : ce1;
  assign gain     = {1'b0, ce_other} + {8'b0, rd.deg} - {8'b0, rd.scn};
  assign keep     = {1'b0, ce_same} - {8'b0, rd.scn};
  assign val      = (gain < keep) ? gain : keep;
  assign better   = pend && !(item.action == ACT_FLIP_C0 && rd.color) &&
                    (!found || val > best);

  // status to the controller
  always_comb begin
    stat.range_ok  = (item.action == ACT_ADD) ? (a_ok && b_ok && item.vertex_a != item.vertex_b)
                                              : a_ok;
    stat.is_dup    = a_rdata[addr_b];
    stat.col_same  = (rd.color == item.color_value);
    stat.clr_last  = (cnt == CW'(MAX_VERTICES - 1));
    stat.nbr_done  = (cnt == CW'(MAX_VERTICES)) && !pend;
    stat.scan_done = (cnt >= n) && !pend;
    stat.found     = found;
  end

  // memory addresses and write data
  always_comb begin
    raddr   = '0;
    w_we    = 1'b0;
    w_waddr = '0;
    w_wdata = '0;
    a_we    = 1'b0;
    a_waddr = '0;
    a_wdata = '0;
    unique case (cmd.op)
      DP_CLR: begin
        w_we    = 1'b1;
        w_waddr = cnt[AW-1:0];
        a_we    = 1'b1;
        a_waddr = cnt[AW-1:0];
      end
      DP_ADD_RD, DP_COL_RD: begin
        raddr = addr_a;
      end
      DP_ADD_CHK: begin
        raddr   = addr_b;
        a_we    = !a_rdata[addr_b];
        a_waddr = addr_a;
        a_wdata = a_rdata | (MAX_VERTICES'(1) << addr_b);
      end
      DP_ADD_WB: begin
        a_we    = 1'b1;
        a_waddr = addr_b;
        a_wdata = a_rdata | (MAX_VERTICES'(1) << addr_a);
        w_we    = 1'b1;
        w_waddr = addr_b;
        w_wdata = '{color: rd.color, scn: rd.scn + {7'b0, eq_n}, deg: rd.deg + 8'd1};
      end
      DP_ADD_WA: begin
        w_we    = 1'b1;
        w_waddr = addr_a;
        w_wdata = '{color: wa.color, scn: wa.scn + {7'b0, eq}, deg: wa.deg + 8'd1};
      end
      DP_FLIP_RD: begin
        raddr = v;
      end
      DP_FLIP_UPD: begin
        w_we    = 1'b1;
        w_waddr = v;
        w_wdata = '{color: !rd.color, scn: rd.deg - rd.scn, deg: rd.deg};
      end
      DP_NBR: begin
        raddr   = cnt[AW-1:0];
        w_we    = pend && adj_row[pend_idx];
        w_waddr = pend_idx;
        w_wdata = '{color: rd.color,
                    scn: (rd.color == c_old) ? rd.scn - 8'd1 : rd.scn + 8'd1,
                    deg: rd.deg};
      end
      DP_SCAN: begin
        raddr = cnt[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  bfs_ram #(.WIDTH(WW), .DEPTH(MAX_VERTICES)) u_word_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (raddr),
    .rdata (w_rdata)
  );

  bfs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (raddr),
    .rdata (a_rdata)
  );

  // control registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 9'd256;
      cnt          <= '0;
      pend         <= 1'b0;
      found        <= 1'b0;
      ce0          <= '0;
      ce1          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
      result_valid <= cmd.reply;
      unique case (cmd.op)
        DP_IDLE: begin
          cnt   <= '0;
          pend  <= 1'b0;
          found <= 1'b0;
        end
        DP_CLR: begin
          cnt <= cnt + CW'(1);
          ce0 <= '0;
          ce1 <= '0;
        end
        DP_ADD_WB: begin
          if (eq_n) begin
            if (rd.color) begin
              ce1 <= ce1 + CE_W'(1);
            end else begin
              ce0 <= ce0 + CE_W'(1);
            end
          end
        end
        DP_FLIP_UPD: begin
          cnt  <= '0;
          pend <= 1'b0;
          if (rd.color) begin
            ce1 <= ce1 - {7'b0, rd.scn};
            ce0 <= ce0 + {7'b0, rd.deg - rd.scn};
          end else begin
            ce0 <= ce0 - {7'b0, rd.scn};
            ce1 <= ce1 + {7'b0, rd.deg - rd.scn};
          end
        end
        DP_NBR: begin
          if (cnt < CW'(MAX_VERTICES)) begin
            cnt  <= cnt + CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        DP_SCAN: begin
          if (cnt < n) begin
            cnt  <= cnt + CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (better) begin
            found <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
    end
    if (cmd.op == DP_ADD_CHK) begin
      wa <= rd;
    end
    if (cmd.op == DP_ADD_WB) begin
      eq <= eq_n;
    end
    if (cmd.op == DP_COL_RD) begin
      v <= addr_a;
    end
    if (cmd.op == DP_FLIP_UPD) begin
      adj_row <= a_rdata;
      c_old   <= rd.color;
    end
    if (cmd.op == DP_NBR || cmd.op == DP_SCAN) begin
      pend_idx <= cnt[AW-1:0];
    end
    if (cmd.op == DP_SCAN && better) begin
      best <= val;
      v    <= pend_idx;
    end
    if (cmd.reply) begin
      result.status        <= cmd.rstat;
      result.chosen_vertex <= cmd.rchosen ? 8'(v) : 8'd0;
      result.score         <= (ce0 < ce1) ? ce0 : ce1;
      result.edges_color0  <= ce0;
      result.edges_color1  <= ce1;
    end
  end

endmodule

// ===== hdl/bipartition_best_flip_search_core.sv =====
// top level of the best-flip bipartition search block
// Usage:
//   Present an item on in_item and raise start while busy is low; the item is
//   taken at that clock edge. Exactly one result follows on result, marked by
//   a one-cycle result_valid strobe; the receiver must take it then.
//   The user writes vertex_count through cfg_we / cfg_wdata while the block
//   idles; the block itself does not enforce this.
// Operation:
//   A flip step scans the per-vertex ram, one vertex per cycle; a flip, from
//   a flip step or from a set colour that changes the colour, then makes a
//   pass over the flipped vertex's adjacency row that updates neighbour
//   counts, one vertex per cycle through one ram write port.
//   busy stays high from acceptance until the result strobe, except for an
//   unknown action, which never raises busy; one item at a time.
// Reset:
//   reset runs a clearing pass over every address of both rams with busy
//   high and no result; vertex_count returns to 256.
module bipartition_best_flip_search_core #(
  parameter int MAX_VERTICES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bfs_pkg::in_item_t  in_item,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata,
  output logic               result_valid,
  output bfs_pkg::out_item_t result
);
  import bfs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  bfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (in_item.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // storage and arithmetic
  bfs_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_item      (in_item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== sim/tb.sv =====
// testbench for the best-flip bipartition search block
`timescale 1ns / 1ps

// scoreboard: tracks the graph, predicts each result and checks it
class flip_search_board;
  bit          adj[256][256];
  bit          color[256];
  int unsigned scn[256];
  int unsigned deg[256];
  int unsigned edges[2];
  int unsigned vcount;
  bfs_pkg::out_item_t pending[$];
  int          errors;

  function new();
    vcount = 256;
    errors = 0;
    wipe();
  endfunction

  function void wipe();
    foreach (adj[i, j]) adj[i][j] = 0;
    foreach (color[i]) begin
      color[i] = 0;
      scn[i] = 0;
      deg[i] = 0;
    end
    edges[0] = 0;
    edges[1] = 0;
  endfunction

  function void flip(int unsigned v);
    bit c;
    c = color[v];
    edges[c] -= scn[v];
    scn[v] = deg[v] - scn[v];
    edges[!c] += scn[v];
    color[v] = !c;
    for (int u = 0; u < 256; u++)
      if (u != v && adj[v][u]) begin
        if (color[u] == c) scn[u]--;
        else scn[u]++;
      end
  endfunction

  // note an accepted item and queue its expected result
  function void note_item(bfs_pkg::in_item_t it);
    bfs_pkg::out_item_t r;
    int unsigned n, a, b, best, g, k, val;
    bit found;
    n = (vcount > 256) ? 256 : vcount;
    a = it.vertex_a;
    b = it.vertex_b;
    r = '0;
    r.status = bfs_pkg::ST_DONE;
    case (it.action)
      bfs_pkg::ACT_CLEAR: wipe();
      bfs_pkg::ACT_ADD: begin
        if (a >= n || b >= n || a == b || adj[a][b]) r.status = bfs_pkg::ST_IGNORED;
        else begin
          adj[a][b] = 1;
          adj[b][a] = 1;
          deg[a]++;
          deg[b]++;
          if (color[a] == color[b]) begin
            scn[a]++;
            scn[b]++;
            edges[color[a]]++;
          end
        end
      end
      bfs_pkg::ACT_COLOR: begin
        if (a >= n) r.status = bfs_pkg::ST_IGNORED;
        else if (color[a] != it.color_value) flip(a);
      end
      bfs_pkg::ACT_FLIP_ANY, bfs_pkg::ACT_FLIP_C0: begin
        found = 0;
        best = 0;
        for (int unsigned i = 0; i < n; i++) begin
          if (it.action == bfs_pkg::ACT_FLIP_C0 && color[i]) continue;
          g = edges[!color[i]] + deg[i] - scn[i];
          k = edges[color[i]] - scn[i];
          val = (g < k) ? g : k;
          if (!found || val > best) begin
            found = 1;
            best = val;
            r.chosen_vertex = i[7:0];
          end
        end
        if (found) flip(r.chosen_vertex);
        else r.status = bfs_pkg::ST_NO_CAND;
      end
      default: r.status = bfs_pkg::ST_IGNORED;
    endcase
    r.edges_color0 = edges[0][14:0];
    r.edges_color1 = edges[1][14:0];
    r.score = (edges[0] < edges[1]) ? edges[0][14:0] : edges[1][14:0];
    pending.push_back(r);
  endfunction

  // compare a result with the oldest expectation
  function void check_result(bfs_pkg::out_item_t got);
    bfs_pkg::out_item_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: result with none expected, actual %p", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      $display("%0t: expected %p, actual %p", $time, exp_r, got);
      errors++;
    end
  endfunction
endclass

module tb;
  import bfs_pkg::*;

  logic      clk = 0;
  logic      rst = 1;
  logic      start = 0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      cfg_we = 0;
  logic [8:0] cfg_wdata = '0;
  logic      result_valid;
  out_item_t result;

  flip_search_board board = new();
  int        cycles = 0;
  int        idle_pct = 31;
  int        hot_v = 12;

  bipartition_best_flip_search_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result_valid(result_valid),
    .result(result)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // sample results and watch the time limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid) board.check_result(result);
    if (cycles > 3000000) begin
      $display("bipartition_best_flip_search_core: mismatch");
      $finish;
    end
  end

  // send one item, with an optional idle gap first; start stays high
  // afterwards until the next idle gap or the next caller drops it
  task automatic send(logic [2:0] act, logic [7:0] a, logic [7:0] b, logic c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    in_item <= '{action: act, vertex_a: a, vertex_b: b, color_value: c};
    start <= 1;
    // busy is stable at the falling edge; the next rising edge accepts
    while (busy) @(negedge clk);
    @(posedge clk);
    board.note_item(in_item);
    @(negedge clk);
  endtask

  // wait out all results, then write the vertex count
  task automatic set_count(logic [8:0] v);
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    board.vcount = v;
  endtask

  // mostly-valid random item drawn over the first hot_v vertices
  task automatic random_item();
    int r;
    logic [7:0] a, b;
    r = $urandom_range(99);
    a = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(hot_v - 1));
    b = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(hot_v - 1));
    if (r < 1) send(ACT_CLEAR, a, b, 1'($urandom));
    else if (r < 45) send(ACT_ADD, a, b, 1'($urandom));
    else if (r < 65) send(ACT_COLOR, a, b, 1'($urandom));
    else if (r < 82) send(ACT_FLIP_ANY, a, b, 1'($urandom));
    else if (r < 97) send(ACT_FLIP_C0, a, b, 1'($urandom));
    else send(3'($urandom_range(7, 5)), a, b, 1'($urandom));
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: extremes, every action, special cases
    send(ACT_FLIP_ANY, 0, 0, 0);
    send(ACT_ADD, 0, 255, 0);
    send(ACT_ADD, 255, 0, 1);
    send(ACT_ADD, 7, 7, 0);
    send(ACT_ADD, 1, 2, 0);
    send(ACT_ADD, 2, 3, 0);
    send(ACT_COLOR, 255, 0, 1);
    send(ACT_COLOR, 2, 0, 0);
    send(ACT_FLIP_ANY, 0, 0, 0);
    send(ACT_FLIP_C0, 0, 0, 0);
    send(3'd5, 8'hff, 8'hff, 1);
    send(3'd7, 0, 0, 0);
    set_count(9'd4);
    send(ACT_ADD, 1, 200, 0);
    send(ACT_COLOR, 4, 0, 1);
    send(ACT_COLOR, 0, 0, 1);
    send(ACT_COLOR, 1, 0, 1);
    send(ACT_COLOR, 2, 0, 1);
    send(ACT_COLOR, 3, 0, 1);
    send(ACT_FLIP_C0, 0, 0, 0);
    set_count(9'd0);
    send(ACT_FLIP_ANY, 0, 0, 0);
    send(ACT_ADD, 0, 1, 0);
    set_count(9'd511);
    send(ACT_CLEAR, 0, 0, 0);
    // random phases over several counts
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin set_count(9'd16); hot_v = 16; end
        1: begin set_count(9'd1); hot_v = 2; end
        2: begin set_count(9'd300); hot_v = 24; end
        3: begin set_count(9'd8); hot_v = 8; idle_pct = 0; end
        4: begin set_count(9'd256); hot_v = 256; idle_pct = 31; end
        default: begin set_count(9'd40); hot_v = 40; end
      endcase
      for (int i = 0; i < 225; i++) random_item();
    end
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("bipartition_best_flip_search_core: match");
    else
      $display("bipartition_best_flip_search_core: mismatch");
    $finish;
  end
endmodule
